// ===== rtl/cses_pkg.sv =====
`default_nettype none
package cses_pkg;

	localparam int DET_W      = 2;
	localparam int CH_W       = 5;
	localparam int ADC_W      = 12;
	localparam int GAIN_W     = 16;
	localparam int OFFS_W     = 18;
	localparam int THR_W      = 20;
	localparam int SUM_W      = 25;
	localparam int PROD_W     = ADC_W + GAIN_W;
	localparam int ROUND_SHIFT = 8;
	localparam int RND_W      = PROD_W + 1 - ROUND_SHIFT;
	localparam int E_W        = RND_W + 2;
	localparam int ADD_W      = E_W - 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = 2;

	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 2'd1;

	localparam logic [THR_W-1:0] THRESHOLD_RST = 20'd32768;
	localparam logic [SUM_W-1:0] UPPER_RST     = 25'd524288;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [SUM_W-1:0] upper;
	} cfg_t;

	// classified sample handed from the front to the back
	typedef struct packed {
		logic                     ok;
		logic                     eoe;
		logic                     back;
		logic [DET_W-1:0]         det;
		logic [ADC_W-1:0]         adc;
		logic [GAIN_W-1:0]        gain;
		logic signed [OFFS_W-1:0] offs;
	} q_item_t;

endpackage
`default_nettype wire

// ===== rtl/calibrated_strip_energy_sum.sv =====
// throughput: one item per cycle while the queue is not full, loads and samples alike, through one table port
// and one multiply-accumulate pipe; an event end holds the back pipe while the
// previous event still has results waiting
// results: after the end-of-event transfer the sample passes the front stage, the queue, the back
// product and sum stages and the result buffer; then one result per cycle per detector while out_ready holds
// reset: control, config and side sums reset at once; calibration table undefined
`default_nettype none
module calibrated_strip_energy_sum import cses_pkg::*; #(
	parameter int NUM_DETECTORS         = 4,
	parameter int CHANNELS_PER_DETECTOR = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [DET_W-1:0]         detector,
	input  logic [CH_W-1:0]          channel,
	input  logic [ADC_W-1:0]         adc_code,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [OFFS_W-1:0] offset,
	input  logic                     end_of_event,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DET_W-1:0]         detector_index,
	output logic [SUM_W-1:0]         front_energy,
	output logic [SUM_W-1:0]         back_energy,
	output logic                     front_in_window,
	output logic                     back_in_window,
	output logic                     both_in_window,
	output logic                     last_result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

	cfg_t    cfg_q;
	q_item_t f_item;
	q_item_t q_head;
	logic    f_valid;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.upper     <= UPPER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				REG_UPPER:     cfg_q.upper     <= cfg_wdata[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	cses_front #(
		.NUM_DETECTORS(NUM_DETECTORS),
		.CHANNELS_PER_DETECTOR(CHANNELS_PER_DETECTOR)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.detector(detector),
		.channel(channel),
		.adc_code(adc_code),
		.gain(gain),
		.offset(offset),
		.end_of_event(end_of_event),
		.item(f_item),
		.item_valid(f_valid),
		.item_full(q_full)
	);

	cses_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.push_item(f_item),
		.full(q_full),
		.pop(q_pop),
		.pop_item(q_head),
		.empty(q_empty)
	);

	cses_back #(
		.NUM_DETECTORS(NUM_DETECTORS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(q_head),
		.q_empty(q_empty),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.detector_index(detector_index),
		.front_energy(front_energy),
		.back_energy(back_energy),
		.front_in_window(front_in_window),
		.back_in_window(back_in_window),
		.both_in_window(both_in_window),
		.last_result(last_result)
	);

endmodule
`default_nettype wire

// ===== rtl/cses_front.sv =====
`default_nettype none
module cses_front import cses_pkg::*; #(
	parameter int NUM_DETECTORS         = 4,
	parameter int CHANNELS_PER_DETECTOR = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [DET_W-1:0]         detector,
	input  logic [CH_W-1:0]          channel,
	input  logic [ADC_W-1:0]         adc_code,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [OFFS_W-1:0] offset,
	input  logic                     end_of_event,
	output q_item_t                  item,
	output logic                     item_valid,
	input  logic                     item_full
);

	localparam int DEPTH = NUM_DETECTORS * CHANNELS_PER_DETECTOR;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = GAIN_W + OFFS_W;

	logic [TW-1:0] tab_mem [DEPTH];
	logic [TW-1:0] rd_s1;
	logic [31:0]   idx_w;
	logic [AW-1:0] addr;
	logic          in_range;
	logic          accept;
	logic          take_sample;
	logic          v_s1;
	logic          ok_s1;
	logic          eoe_s1;
	logic          back_s1;
	logic [DET_W-1:0] det_s1;
	logic [ADC_W-1:0] adc_s1;

	assign accept   = in_valid && in_ready;
	assign in_ready = !v_s1 || !item_full;
	assign in_range = (32'(detector) < 32'(NUM_DETECTORS)) &&
		(32'(channel) < 32'(CHANNELS_PER_DETECTOR));
	assign idx_w    = 32'(detector) * 32'(CHANNELS_PER_DETECTOR) + 32'(channel);
	assign addr     = idx_w[AW-1:0];
	assign take_sample = accept && (func == FUNC_SAMPLE);

	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_LOAD) && in_range) begin
			tab_mem[addr] <= {gain, offset};
		end
		if (take_sample && in_range) begin
			rd_s1 <= tab_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			ok_s1   <= in_range;
			eoe_s1  <= end_of_event;
			back_s1 <= 32'(channel) >= 32'(CHANNELS_PER_DETECTOR / 2);
			det_s1  <= detector;
			adc_s1  <= adc_code;
		end
	end

	// loads finish at the table write, only samples go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= take_sample;
		end
	end

	assign item_valid = v_s1;
	always_comb begin
		item.ok   = ok_s1;
		item.eoe  = eoe_s1;
		item.back = back_s1;
		item.det  = det_s1;
		item.adc  = adc_s1;
		item.gain = rd_s1[TW-1:OFFS_W];
		item.offs = $signed(rd_s1[OFFS_W-1:0]);
	end

endmodule
`default_nettype wire

// ===== rtl/cses_queue.sv =====
`default_nettype none
module cses_queue import cses_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output q_item_t pop_item,
	output logic    empty
);

	q_item_t             q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cses_back.sv =====
`default_nettype none
module cses_back import cses_pkg::*; #(
	parameter int NUM_DETECTORS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  q_item_t          head,
	input  logic             q_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DET_W-1:0] detector_index,
	output logic [SUM_W-1:0] front_energy,
	output logic [SUM_W-1:0] back_energy,
	output logic             front_in_window,
	output logic             back_in_window,
	output logic             both_in_window,
	output logic             last_result
);

	localparam int DW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;

	logic                     adv;
	logic                     emit_free;
	logic                     snap_load;
	logic                     idx_last;

	logic                     v_s1;
	logic                     ok_s1;
	logic                     eoe_s1;
	logic                     back_s1;
	logic [DET_W-1:0]         det_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic signed [OFFS_W-1:0] offs_s1;

	logic [PROD_W:0]          rsum;
	logic signed [E_W-1:0]    energy;
	logic signed [E_W-1:0]    thr_ext;

	logic                     v_s2;
	logic                     pass_s2;
	logic                     eoe_s2;
	logic                     back_s2;
	logic [DET_W-1:0]         det_s2;
	logic [ADD_W-1:0]         add_s2;

	logic [SUM_W-1:0] front_q [NUM_DETECTORS];
	logic [SUM_W-1:0] back_q  [NUM_DETECTORS];
	logic [SUM_W-1:0] front_nxt [NUM_DETECTORS];
	logic [SUM_W-1:0] back_nxt  [NUM_DETECTORS];
	logic [SUM_W-1:0] snap_f_q [NUM_DETECTORS];
	logic [SUM_W-1:0] snap_b_q [NUM_DETECTORS];

	logic             busy_q;
	logic [DW-1:0]    idx_q;

	assign idx_last  = idx_q == DW'(NUM_DETECTORS - 1);
	assign emit_free = !busy_q || (out_ready && idx_last);
	// the whole back pipe holds while an event end waits for the result buffer
	assign adv       = !(v_s2 && eoe_s2 && !emit_free);
	assign pop       = !q_empty && adv;
	assign snap_load = adv && v_s2 && eoe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ok_s1   <= head.ok;
			eoe_s1  <= head.eoe;
			back_s1 <= head.back;
			det_s1  <= head.det;
			prod_s1 <= PROD_W'(head.adc) * PROD_W'(head.gain);
			offs_s1 <= head.offs;
		end
	end

	// round to nearest into 2^-16 units, then add the signed offset
	assign rsum    = {1'b0, prod_s1} + ROUND_HALF;
	assign energy  = $signed({{(E_W - RND_W){1'b0}}, rsum[PROD_W:ROUND_SHIFT]}) +
		$signed({{(E_W - OFFS_W){offs_s1[OFFS_W-1]}}, offs_s1});
	assign thr_ext = $signed({{(E_W - THR_W){1'b0}}, cfg.threshold});

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pass_s2 <= ok_s1 && (energy > thr_ext);
			eoe_s2  <= eoe_s1;
			back_s2 <= back_s1;
			det_s2  <= det_s1;
			add_s2  <= energy[ADD_W-1:0];
		end
	end

	always_comb begin
		logic [SUM_W:0] fs;
		logic [SUM_W:0] bs;
		for (int d = 0; d < NUM_DETECTORS; d++) begin
			fs = {1'b0, front_q[d]} + (SUM_W + 1)'(add_s2);
			bs = {1'b0, back_q[d]} + (SUM_W + 1)'(add_s2);
			front_nxt[d] = front_q[d];
			back_nxt[d]  = back_q[d];
			if (v_s2 && pass_s2 && (32'(det_s2) == d)) begin
				if (!back_s2) begin
					front_nxt[d] = fs[SUM_W] ? '1 : fs[SUM_W-1:0];
				end else begin
					back_nxt[d] = bs[SUM_W] ? '1 : bs[SUM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DETECTORS; d++) begin
				front_q[d] <= '0;
				back_q[d]  <= '0;
			end
		end else if (adv && v_s2) begin
			for (int d = 0; d < NUM_DETECTORS; d++) begin
				front_q[d] <= eoe_s2 ? '0 : front_nxt[d];
				back_q[d]  <= eoe_s2 ? '0 : back_nxt[d];
			end
		end
	end

	// result buffer shifts toward entry zero on each transfer
	always_ff @(posedge clk) begin
		if (snap_load) begin
			for (int d = 0; d < NUM_DETECTORS; d++) begin
				snap_f_q[d] <= front_nxt[d];
				snap_b_q[d] <= back_nxt[d];
			end
		end else if (busy_q && out_ready) begin
			for (int d = 0; d < NUM_DETECTORS - 1; d++) begin
				snap_f_q[d] <= snap_f_q[d+1];
				snap_b_q[d] <= snap_b_q[d+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (snap_load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (idx_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_valid       = busy_q;
	assign detector_index  = DET_W'(idx_q);
	assign front_energy    = snap_f_q[0];
	assign back_energy     = snap_b_q[0];
	assign front_in_window = (snap_f_q[0] > {{(SUM_W - THR_W){1'b0}}, cfg.threshold}) &&
		(snap_f_q[0] < cfg.upper);
	assign back_in_window  = (snap_b_q[0] > {{(SUM_W - THR_W){1'b0}}, cfg.threshold}) &&
		(snap_b_q[0] < cfg.upper);
	assign both_in_window  = front_in_window && back_in_window;
	assign last_result     = idx_last;

endmodule
`default_nettype wire

// ===== rtl/cses_checker.sv =====
`default_nettype none
module cses_checker import cses_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [DET_W-1:0] detector_index,
	input logic [SUM_W-1:0] front_energy,
	input logic [SUM_W-1:0] back_energy,
	input logic             front_in_window,
	input logic             back_in_window,
	input logic             both_in_window,
	input logic             last_result
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(detector_index) &&
		$stable(front_energy) && $stable(back_energy) && $stable(last_result))
		else $error("result changed while stalled");

	a_both_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> both_in_window == (front_in_window && back_in_window))
		else $error("both_in_window disagrees with side flags");

	// results of one event go out without gaps in detector order
	a_next_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=>
		out_valid && (detector_index == $past(detector_index) + 2'd1))
		else $error("detector sequence broken");

	a_new_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> !out_valid || (detector_index == 2'd0))
		else $error("event did not start at detector zero");

endmodule

bind calibrated_strip_energy_sum cses_checker u_cses_checker (.*);
`default_nettype wire
